// ===== rtl/sliding_window_median_top_macros.svh =====
// Assertion macros used by the sliding-window median checker.
// Depends on nothing; the including scope provides aclk and aresetn.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define SWM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
// Shared constants and types of the sliding-window median filter.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Default sizes of the filter.
    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed field widths of the stream and configuration ports.
    localparam int LEN_W       = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_W       = 33;
    localparam int OUT_TDATA_W = 40;

    // Window length after reset.
    localparam int RESET_LEN = 3;

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic advance;  // a word is taken this cycle
        logic restart;  // the word starts a new sequence
        logic flush;    // configuration write empties the window
    } step_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One cell of the sorted window: holds one sample, its age and a valid bit.
// Depends on swm_pkg; instantiated in a row by swm_chain.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_W       = 5
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  swm_pkg::step_ctl_t           ctl,
    input  wire signed [SAMPLE_BITS-1:0] sample,
    input  wire        [AGE_W-1:0]       oldest_age,
    // Neighbor below (lower sorted position).
    input  wire                          lo_vld,
    input  wire signed [SAMPLE_BITS-1:0] lo_val,
    input  wire        [AGE_W-1:0]       lo_age,
    input  wire                          lo_gtp,
    input  wire                          lo_ele,
    // Neighbor above (higher sorted position).
    input  wire                          hi_vld,
    input  wire signed [SAMPLE_BITS-1:0] hi_val,
    input  wire        [AGE_W-1:0]       hi_age,
    input  wire                          hi_gt,
    // Own state and chain signals handed to the neighbors.
    output logic                         vld,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic       [AGE_W-1:0]       age,
    output logic                         vld_q,
    output logic                         gt,
    output logic                         gtp,
    output logic                         ele
);

    logic                          vld_reg, vld_next;
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic        [AGE_W-1:0]       age_reg, age_next;
    logic                          evict;

    // A restart makes the held samples invisible to this word.
    assign vld   = vld_reg & ~ctl.restart;
    assign val   = val_reg;
    assign age   = age_reg;
    assign vld_q = vld_reg;

    // Empty cells compare as greater, so the insertion point is found below them.
    assign gt = ~vld | (val_reg > sample);

    // The oldest sample leaves; eviction at or below this cell ripples upward.
    assign evict = vld & (age_reg == oldest_age);
    assign ele   = evict | lo_ele;
    assign gtp   = ele ? hi_gt : gt;

    // Pick the new content: from below when the insert point is lower, the
    // new sample at the insert point, otherwise the closed-up own entry.
    always_comb begin
        vld_next = vld_reg;
        val_next = val_reg;
        age_next = age_reg;
        if (ctl.flush) begin
            vld_next = 1'b0;
        end else if (ctl.advance) begin
            if (lo_gtp) begin
                vld_next = lo_ele ? vld     : lo_vld;
                val_next = lo_ele ? val_reg : lo_val;
                age_next = AGE_W'((lo_ele ? age_reg : lo_age) + 1'b1);
            end else if (gtp) begin
                vld_next = 1'b1;
                val_next = sample;
                age_next = '0;
            end else begin
                vld_next = ele ? hi_vld : vld;
                val_next = ele ? hi_val : val_reg;
                age_next = AGE_W'((ele ? hi_age : age_reg) + 1'b1);
            end
        end
    end

    // Valid bit is control state; sample and age are payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

`default_nettype wire

// ===== rtl/swm_chain.sv =====
// Row of swm_cell instances that keeps the window sorted, plus median taps.
// Depends on swm_pkg and swm_cell.
`timescale 1ns / 1ps
`default_nettype none

module swm_chain #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_W       = 5
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  swm_pkg::step_ctl_t            ctl,
    input  wire signed [SAMPLE_BITS-1:0]  sample,
    input  wire        [AGE_W-1:0]        oldest_age,
    input  wire        [AGE_W-1:0]        tap_a,
    input  wire        [AGE_W-1:0]        tap_b,
    output logic signed [SAMPLE_BITS-1:0] med_a,
    output logic signed [SAMPLE_BITS-1:0] med_b,
    output logic                          full
);

    logic                          vld_w [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] val_w [MAX_WINDOW];
    logic        [AGE_W-1:0]       age_w [MAX_WINDOW];
    logic                          vq_w  [MAX_WINDOW];
    logic                          gt_w  [MAX_WINDOW];
    logic                          gtp_w [MAX_WINDOW];
    logic                          ele_w [MAX_WINDOW];

    // Cells are wired to their neighbors; the ends see an empty slot.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic                          lo_vld, lo_gtp, lo_ele, hi_vld, hi_gt;
        logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
        logic        [AGE_W-1:0]       lo_age, hi_age;

        if (i == 0) begin : g_lo_end
            assign lo_vld = 1'b0;
            assign lo_val = '0;
            assign lo_age = '0;
            assign lo_gtp = 1'b0;
            assign lo_ele = 1'b0;
        end else begin : g_lo
            assign lo_vld = vld_w[i-1];
            assign lo_val = val_w[i-1];
            assign lo_age = age_w[i-1];
            assign lo_gtp = gtp_w[i-1];
            assign lo_ele = ele_w[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_hi_end
            assign hi_vld = 1'b0;
            assign hi_val = '0;
            assign hi_age = '0;
            assign hi_gt  = 1'b1;
        end else begin : g_hi
            assign hi_vld = vld_w[i+1];
            assign hi_val = val_w[i+1];
            assign hi_age = age_w[i+1];
            assign hi_gt  = gt_w[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .sample     (sample),
            .oldest_age (oldest_age),
            .lo_vld     (lo_vld),
            .lo_val     (lo_val),
            .lo_age     (lo_age),
            .lo_gtp     (lo_gtp),
            .lo_ele     (lo_ele),
            .hi_vld     (hi_vld),
            .hi_val     (hi_val),
            .hi_age     (hi_age),
            .hi_gt      (hi_gt),
            .vld        (vld_w[i]),
            .val        (val_w[i]),
            .age        (age_w[i]),
            .vld_q      (vq_w[i]),
            .gt         (gt_w[i]),
            .gtp        (gtp_w[i]),
            .ele        (ele_w[i])
        );
    end

    // Median taps and the window-full flag, read from the stored cell contents.
    always_comb begin
        med_a = '0;
        med_b = '0;
        full  = 1'b0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (tap_a == AGE_W'(i)) begin
                med_a = med_a | val_w[i];
            end
            if (tap_b == AGE_W'(i)) begin
                med_b = med_b | val_w[i];
            end
            if (oldest_age == AGE_W'(i)) begin
                full = full | vq_w[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_top.sv =====
// Sliding-window median filter: takes one signed sample per word and, once the
// window holds window_len samples, returns twice the window median for every
// sample (the sum of the two middle values, so half values stay exact). A
// word with tuser set empties the window first; writing window_len empties it
// too. The filter sustains one word per clock unless input stalls: a row of
// cells keeps the window sorted and inserts, evicts and ages together, and
// a result is registered first in the cell row and then in the median
// output register. Input stalls only while a result waits at the output.
// Depends on swm_pkg, swm_chain and swm_cell.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Configuration: window_len.
    input  wire                              cfg_wr_en,
    input  wire [swm_pkg::LEN_W-1:0]         cfg_wr_data,
    // Input stream.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [swm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] sample
    input  wire                              s_axis_tuser,  // [0] restart
    // Result stream.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [swm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [32:0] median_times_two
);

    localparam int AGE_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EFF_W     = $clog2(MAX_WINDOW + 1);
    localparam int RESET_EFF = (swm_pkg::RESET_LEN > MAX_WINDOW) ? MAX_WINDOW
                                                                  : swm_pkg::RESET_LEN;

    logic [EFF_W-1:0]              eff_reg, eff_next;
    logic                          pend_reg, pend_next;
    logic                          mvld_reg, mvld_next;
    logic [swm_pkg::OUT_W-1:0]     med_reg, med_next;

    swm_pkg::step_ctl_t            ctl;
    logic                          s_accept;
    logic                          out_free;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [AGE_W-1:0]       oldest_age;
    logic        [AGE_W-1:0]       tap_a;
    logic        [AGE_W-1:0]       tap_b;
    logic signed [SAMPLE_BITS-1:0] med_a;
    logic signed [SAMPLE_BITS-1:0] med_b;
    logic signed [SAMPLE_BITS:0]   med_sum;

    // Handshakes: a processed word only holds the input back when it has a
    // result that cannot yet move to the output register.
    assign out_free      = ~mvld_reg | m_axis_tready;
    assign s_axis_tready = ~pend_reg | out_free | ~full;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    assign sample      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign ctl.advance = s_accept;
    assign ctl.restart = s_accept & s_axis_tuser;
    assign ctl.flush   = cfg_wr_en;

    // Age of the oldest sample in a full window, and the two middle positions.
    assign oldest_age = AGE_W'(eff_reg - EFF_W'(1));
    assign tap_a      = AGE_W'((eff_reg - EFF_W'(1)) >> 1);
    assign tap_b      = AGE_W'(eff_reg >> 1);

    swm_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AGE_W       (AGE_W)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sample     (sample),
        .oldest_age (oldest_age),
        .tap_a      (tap_a),
        .tap_b      (tap_b),
        .med_a      (med_a),
        .med_b      (med_b),
        .full       (full)
    );

    // Window length written through the configuration port, clamped to 1..MAX_WINDOW.
    always_comb begin
        eff_next = eff_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                eff_next = EFF_W'(1);
            end else if (32'(cfg_wr_data) > 32'(MAX_WINDOW)) begin
                eff_next = EFF_W'(MAX_WINDOW);
            end else begin
                eff_next = EFF_W'(cfg_wr_data);
            end
        end
    end

    // Median stage: the two middle values, each sign-extended by one bit, summed.
    assign med_sum = {med_a[SAMPLE_BITS-1], med_a} + {med_b[SAMPLE_BITS-1], med_b};

    always_comb begin
        pend_next = pend_reg;
        mvld_next = mvld_reg;
        med_next  = med_reg;
        if (m_axis_tready) begin
            mvld_next = 1'b0;
        end
        if (pend_reg & full & out_free) begin
            mvld_next = 1'b1;
            med_next  = swm_pkg::OUT_W'(med_sum);
        end
        if (s_accept) begin
            pend_next = 1'b1;
        end else if (out_free | ~full) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_reg  <= EFF_W'(RESET_EFF);
            pend_reg <= 1'b0;
            mvld_reg <= 1'b0;
        end else begin
            eff_reg  <= eff_next;
            pend_reg <= pend_next;
            mvld_reg <= mvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        med_reg <= med_next;
    end

    assign m_axis_tvalid = mvld_reg;
    assign m_axis_tdata  = swm_pkg::OUT_TDATA_W'(med_reg);

endmodule

`default_nettype wire

// ===== rtl/swm_checker.sv =====
// Port-level checker for the sliding-window median filter, bound to the top.
// Depends on swm_pkg and sliding_window_median_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_median_top_macros.svh"

module swm_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [swm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // A stalled result word keeps its value.
    `SWM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // A fresh result is always caused by a word taken earlier.
    `SWM_ASSERT(a_out_cause, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without a sample two cycles earlier")

    // Input is held back only while a result waits at the output.
    `SWM_ASSERT(a_in_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled with a free output")

    // Reset leaves no result pending.
    `SWM_ASSERT_RST(a_rst_empty, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (.*);

`default_nettype wire

// ===== test/swm_median_checker.sv =====
// Scoreboard for the sliding-window median filter. It watches the window_len
// port and both streams, predicts each median word and compares it.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_median_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire [swm_pkg::LEN_W-1:0]         cfg_wr_data,
    input  wire                              s_axis_tvalid,
    input  wire                              s_axis_tready,
    input  wire [swm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [31:0] sample
    input  wire                              s_axis_tuser,   // [0] restart
    input  wire                              m_axis_tvalid,
    input  wire                              m_axis_tready,
    input  wire [swm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [32:0] median_times_two
    output int                               fail_count,
    output int                               pending_results
);

    localparam int WIN_MAX    = swm_pkg::MAX_WINDOW_DEF;
    localparam int OWED_DEPTH = 64;

    // Predicted window: samples in ascending order, and the sorted position of
    // each held sample in a ring ordered by age, oldest at ring_head.
    logic signed [31:0]          ordered [WIN_MAX];
    logic [4:0]                  age_pos [WIN_MAX];
    int                          ring_head = 0;
    int                          held = 0;
    logic [swm_pkg::LEN_W-1:0]   len_reg = swm_pkg::LEN_W'(swm_pkg::RESET_LEN);

    // Median words still owed by the block, kept in a ring, oldest at owed_rd.
    logic [swm_pkg::OUT_TDATA_W-1:0] owed_medians [OWED_DEPTH];
    int                              owed_rd = 0;
    int                              owed_count = 0;

    initial begin
        fail_count = 0;
        pending_results = 0;
    end

    // A zero length acts as a window of one; lengths above the maximum saturate.
    function automatic int window_size();
        if (len_reg == 0)
            return 1;
        if (len_reg > WIN_MAX)
            return WIN_MAX;
        return int'(len_reg);
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [swm_pkg::OUT_TDATA_W-1:0] got,
                                   input logic [swm_pkg::OUT_TDATA_W-1:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Append one predicted word behind those already owed.
    task automatic owe_median(input logic [swm_pkg::OUT_TDATA_W-1:0] word);
        if (owed_count == OWED_DEPTH) begin
            report_mismatch("too many median words outstanding", '0, word);
        end else begin
            owed_medians[(owed_rd + owed_count) % OWED_DEPTH] = word;
            owed_count++;
        end
    endtask

    // Retire the oldest owed word.
    task automatic retire_median();
        owed_rd = (owed_rd + 1) % OWED_DEPTH;
        owed_count--;
    endtask

    // Take one sample into the window and queue the median word it causes.
    task automatic slide_window(input logic signed [31:0] smp, input logic rst);
        int n;
        int pos;
        int a;
        int p;
        int q;
        logic signed [32:0] med;
        n = window_size();
        if (rst) begin
            ring_head = 0;
            held = 0;
        end
        // Drop the oldest sample; its recorded position is the one removed,
        // even when equal values sit beside it.
        if (held >= n) begin
            pos = int'(age_pos[ring_head]);
            if (pos >= held)
                pos = held - 1;
            for (p = pos; p + 1 < held; p++)
                ordered[p] = ordered[p + 1];
            ring_head = (ring_head + 1) % WIN_MAX;
            held--;
            for (a = 0; a < held; a++) begin
                q = (ring_head + a) % WIN_MAX;
                if (int'(age_pos[q]) > pos)
                    age_pos[q]--;
            end
        end
        // Insert after every held value that is equal or smaller.
        pos = 0;
        while (pos < held && ordered[pos] <= smp)
            pos++;
        for (a = 0; a < held; a++) begin
            q = (ring_head + a) % WIN_MAX;
            if (int'(age_pos[q]) >= pos)
                age_pos[q]++;
        end
        for (p = held; p > pos; p--)
            ordered[p] = ordered[p - 1];
        ordered[pos] = smp;
        age_pos[(ring_head + held) % WIN_MAX] = 5'(pos);
        held++;
        // A full window gives twice its median, exact in 33 bits.
        if (held >= n) begin
            if (n % 2 == 1)
                med = {ordered[n / 2], 1'b0};
            else
                med = {ordered[n / 2 - 1][31], ordered[n / 2 - 1]}
                    + {ordered[n / 2][31], ordered[n / 2]};
            owe_median({{(swm_pkg::OUT_TDATA_W - swm_pkg::OUT_W){1'b0}}, med});
        end
    endtask

    // Sample both streams and the configuration port at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            len_reg = swm_pkg::LEN_W'(swm_pkg::RESET_LEN);
            ring_head = 0;
            held = 0;
            owed_rd = 0;
            owed_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_count == 0) begin
                    report_mismatch("median word with none outstanding", m_axis_tdata, '0);
                end else begin
                    if (m_axis_tdata !== owed_medians[owed_rd])
                        report_mismatch("median_times_two mismatch", m_axis_tdata,
                                        owed_medians[owed_rd]);
                    retire_median();
                end
            end
            // A window_len write also empties the window.
            if (cfg_wr_en) begin
                len_reg = cfg_wr_data;
                ring_head = 0;
                held = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
                slide_window($signed(s_axis_tdata[31:0]), s_axis_tuser);
        end
        pending_results = owed_count;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for sliding_window_median_top: drives samples and window_len
// writes under varying idle and stall rates and gives the verdict.
// Depends on swm_pkg, the block itself and swm_median_checker.

module tb_top;
    import swm_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted word
    localparam int PHASE_ITEMS    = 138;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]       cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_results;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    sliding_window_median_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    swm_median_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #5 aclk = ~aclk;

    // Receiver: stall at random at the current rate.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles in which neither stream moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("sliding_window_median_top test failed");
        $finish;
    end

    // Offer one word after a random gap and hold it until it is taken.
    task automatic feed(input logic [31:0] smp, input logic rst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = $urandom;
            s_axis_tuser = 1'($urandom_range(1));
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = smp;
        s_axis_tuser = rst;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Stop sending until every median word is back and the pipeline is empty.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_window(input logic [LEN_W-1:0] len);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_wr_data = len;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mix of full-range values, small clustered values that give many ties,
    // the extremes, and small steps from the previous sample.
    function automatic logic [31:0] pick_sample(input logic [31:0] prev);
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(8)) - 32'd4;
            7: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default:    return prev + 32'($urandom_range(6)) - 32'd3;
        endcase
    endfunction

    initial begin
        int window_plan [12] = '{1, 32, 2, 5, 0, 63, 17, 31, 4, 33, 8, 3};
        logic [31:0] last_sample;
        int ph;
        int k;
        last_sample = '0;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset length of three: no word until the window is full.
        feed(32'h8000_0000, 1'b0);
        feed(32'h7fff_ffff, 1'b0);
        feed(32'h0000_0000, 1'b0);
        // Runs of equal values, at minus one and at both extremes.
        feed(32'hffff_ffff, 1'b0);
        feed(32'hffff_ffff, 1'b0);
        feed(32'hffff_ffff, 1'b0);
        feed(32'h7fff_ffff, 1'b0);
        feed(32'h7fff_ffff, 1'b0);
        feed(32'h7fff_ffff, 1'b0);
        feed(32'h8000_0000, 1'b0);
        feed(32'h8000_0000, 1'b0);
        feed(32'h8000_0000, 1'b0);
        // Restart with a sample: it opens a new sequence.
        feed(32'd7, 1'b1);
        feed(32'd7, 1'b0);
        feed(32'd5, 1'b0);
        // Even window: sums of the two middle values at the limits.
        write_window(6'd2);
        feed(32'h7fff_ffff, 1'b0);
        feed(32'h7fff_ffff, 1'b0);
        feed(32'h8000_0000, 1'b0);
        feed(32'h8000_0000, 1'b0);
        feed(32'd5, 1'b0);
        feed(32'hffff_fffb, 1'b0);
        // Zero length acts as a window of one sample.
        write_window(6'd0);
        feed(32'd9, 1'b0);
        feed(32'hffff_fff7, 1'b1);

        // Random phases, each with its own length and idle pattern.
        for (ph = 0; ph < 12; ph++) begin
            write_window(LEN_W'(window_plan[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // Now and then hold off mid-phase until every word is back.
                if (k == PHASE_ITEMS / 2 && ph % 3 == 0)
                    drain_results();
                last_sample = pick_sample(last_sample);
                feed(last_sample, $urandom_range(79) == 0);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("sliding_window_median_top test passed");
        else
            $display("sliding_window_median_top test failed");
        $finish;
    end

endmodule
